// ===== src/ptcb_pkg.sv =====
`timescale 1ns / 1ps

package ptcb_pkg;

    // Working width of a point coordinate inside the transform chain
    localparam int PW = 36;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 60;

    localparam logic [CFG_INDEX_W-1:0] CFG_YAW_OFFSET    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PITCH_OFFSET  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_OFFSET = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_TILT   = 8'd3;

    typedef struct packed {
        logic signed [23:0] cam_x;
        logic signed [23:0] cam_y;
        logic signed [23:0] cam_z;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
    } ptcb_in_t;

    typedef struct packed {
        logic signed [31:0] base_x;
        logic signed [31:0] base_y;
        logic signed [31:0] base_z;
    } ptcb_out_t;

endpackage

// ===== src/ptcb_rot.sv =====
`timescale 1ns / 1ps

// Planar rotation of the pair (a, b) by a binary angle, then offset add:
//   a' = round(c*a - s*b) + off_a, b' = round(s*a + c*b) + off_b, t' = t + off_t
// Three stages: table read, products, sum/round/offset.
module ptcb_rot
    import ptcb_pkg::*;
#(
    parameter int TABLE_BITS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_take,
    input  logic [15:0]          angle,
    input  logic signed [PW-1:0] a,
    input  logic signed [PW-1:0] b,
    input  logic signed [PW-1:0] t,
    input  logic signed [PW-1:0] off_a,
    input  logic signed [PW-1:0] off_b,
    input  logic signed [PW-1:0] off_t,
    output logic                 out_valid,
    input  logic                 out_take,
    output logic signed [PW-1:0] out_a,
    output logic signed [PW-1:0] out_b,
    output logic signed [PW-1:0] out_t
);

    localparam int TN     = 1 << TABLE_BITS;
    localparam int AW     = TABLE_BITS + 1;
    localparam int PROD_W = PW + 18;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave sine entry, Taylor series in Q30 rounded to Q16
    function automatic logic [16:0] sine_entry(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        int          n;
        x    = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 7; n++)
        begin
            term = (term * x2) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                default: term = term / 64'd210;
            endcase
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = 64'(sum + 8192) >> 14;
        if (v > 64'd65536)
            v = 64'd65536;
        return 17'(v);
    endfunction

    logic [16:0] sine_rom [0:TN];

    for (genvar gk = 0; gk <= TN; gk++)
    begin : g_rom
        assign sine_rom[gk] = sine_entry(gk);
    end

    // Odd quadrants read the table mirrored
    function automatic logic [AW-1:0] rom_addr(input logic [15:0] ph);
        logic [TABLE_BITS-1:0] idx;
        idx = ph[13 -: TABLE_BITS];
        if (ph[14])
            return AW'(TN) - {1'b0, idx};
        else
            return {1'b0, idx};
    endfunction

    logic                 take1, take2, take3;
    logic                 v1_reg, v2_reg, v3_reg;

    logic [15:0]          cos_phase;
    logic [16:0]          sv_reg, cv_reg;
    logic                 sneg_reg, cneg_reg;
    logic signed [PW-1:0] a1_reg, b1_reg, t1_reg;

    logic signed [17:0]     s_val, c_val;
    logic signed [PROD_W-1:0] ca_reg, sb_reg, sa_reg, cb_reg;
    logic signed [PW-1:0]   t2_reg;

    logic signed [SUM_W-1:0] sum_a, sum_b;
    logic signed [SUM_W-1:0] rnd_a, rnd_b;
    logic signed [PW-1:0]    a3_reg, b3_reg, t3_reg;

    assign take3   = !v3_reg || out_take;
    assign take2   = !v2_reg || take3;
    assign take1   = !v1_reg || take2;
    assign in_take = take1;

    assign cos_phase = angle + 16'h4000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (take1)
                v1_reg <= in_valid;
            if (take2)
                v2_reg <= v1_reg;
            if (take3)
                v3_reg <= v2_reg;
        end
    end

    // Stage 1: table read, two ports
    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            sv_reg   <= sine_rom[rom_addr(angle)];
            cv_reg   <= sine_rom[rom_addr(cos_phase)];
            sneg_reg <= angle[15];
            cneg_reg <= cos_phase[15];
            a1_reg   <= a;
            b1_reg   <= b;
            t1_reg   <= t;
        end
    end

    assign s_val = sneg_reg ? -$signed({1'b0, sv_reg}) : $signed({1'b0, sv_reg});
    assign c_val = cneg_reg ? -$signed({1'b0, cv_reg}) : $signed({1'b0, cv_reg});

    // Stage 2: products
    always_ff @(posedge clk)
    begin
        if (take2)
        begin
            ca_reg <= PROD_W'(c_val) * PROD_W'(a1_reg);
            sb_reg <= PROD_W'(s_val) * PROD_W'(b1_reg);
            sa_reg <= PROD_W'(s_val) * PROD_W'(a1_reg);
            cb_reg <= PROD_W'(c_val) * PROD_W'(b1_reg);
            t2_reg <= t1_reg;
        end
    end

    // Stage 3: round half up out of Q16 to an integer, then offset
    assign sum_a = SUM_W'(ca_reg) - SUM_W'(sb_reg) + SUM_W'(32768);
    assign sum_b = SUM_W'(sa_reg) + SUM_W'(cb_reg) + SUM_W'(32768);
    assign rnd_a = sum_a >>> 16;
    assign rnd_b = sum_b >>> 16;

    always_ff @(posedge clk)
    begin
        if (take3)
        begin
            a3_reg <= PW'(rnd_a) + off_a;
            b3_reg <= PW'(rnd_b) + off_b;
            t3_reg <= t2_reg + off_t;
        end
    end

    assign out_valid = v3_reg;
    assign out_a     = a3_reg;
    assign out_b     = b3_reg;
    assign out_t     = t3_reg;

endmodule

// ===== src/pan_tilt_camera_point_to_base_top.sv =====
`timescale 1ns / 1ps

// Camera-frame point to robot base frame.
// Input channel (in_valid/in_stall/in_data): one camera point plus head yaw and
// pitch per transfer. Output channel (out_valid/out_stall/out_data): the point
// in the base frame, one result per input, in order.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is always
// high; index 0 yaw offset, 1 pitch offset, 2 camera mount offset, 3 camera
// tilt. Unknown indexes are dropped. Write only while the pipeline is empty.
// Each of the three rotations has three stages (table read, multiply, round and
// offset add); the point is registered through them in that order.
// Throughput: one point per clock while out_stall is low; each rotation has its
// own sine table with two read ports, so nothing is shared between items.
// Reset clears all valid bits and the config registers to zero.
// When the receiver stalls, the result holds in the last stage; earlier stages
// keep filling bubbles, and in_stall rises only once all nine stages are full.
module pan_tilt_camera_point_to_base_top
    import ptcb_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  ptcb_in_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ptcb_out_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CFG_DATA_W-1:0] yaw_off_reg, pitch_off_reg, cam_off_reg;
    logic [15:0]           tilt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_off_reg   <= '0;
            pitch_off_reg <= '0;
            cam_off_reg   <= '0;
            tilt_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_YAW_OFFSET:    yaw_off_reg   <= cfg_data;
                CFG_PITCH_OFFSET:  pitch_off_reg <= cfg_data;
                CFG_CAMERA_OFFSET: cam_off_reg   <= cfg_data;
                CFG_CAMERA_TILT:   tilt_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Packed offsets: x in 19:0, y in 39:20, z in 59:40
    logic signed [PW-1:0] yaw_ox, yaw_oy, yaw_oz;
    logic signed [PW-1:0] pit_ox, pit_oy, pit_oz;
    logic signed [PW-1:0] cam_ox, cam_oy, cam_oz;

    assign yaw_ox = PW'($signed(yaw_off_reg[19:0]));
    assign yaw_oy = PW'($signed(yaw_off_reg[39:20]));
    assign yaw_oz = PW'($signed(yaw_off_reg[59:40]));
    assign pit_ox = PW'($signed(pitch_off_reg[19:0]));
    assign pit_oy = PW'($signed(pitch_off_reg[39:20]));
    assign pit_oz = PW'($signed(pitch_off_reg[59:40]));
    assign cam_ox = PW'($signed(cam_off_reg[19:0]));
    assign cam_oy = PW'($signed(cam_off_reg[39:20]));
    assign cam_oz = PW'($signed(cam_off_reg[59:40]));

    // Optical swap: x = cam_z, y = -cam_x, z = -cam_y
    logic signed [PW-1:0] sw_x, sw_y, sw_z;

    assign sw_x = PW'(in_data.cam_z);
    assign sw_y = -PW'(in_data.cam_x);
    assign sw_z = -PW'(in_data.cam_y);

    // Angles ride along the pipeline with their point
    logic [15:0] yaw_s1_reg, yaw_s2_reg, yaw_s3_reg;
    logic [15:0] pitch_s1_reg, pitch_s2_reg, pitch_s3_reg;
    logic [15:0] yaw_s4_reg, yaw_s5_reg, yaw_s6_reg;

    logic                 r1_take, r1_valid, r2_take, r2_valid, r3_take, r3_valid;
    logic signed [PW-1:0] r1_z, r1_x, r1_y;
    logic signed [PW-1:0] r2_z, r2_x, r2_y;
    logic signed [PW-1:0] r3_x, r3_y, r3_z;

    assign in_stall = !r1_take;

    // The rotation modules advance their stages on the same take terms,
    // so these side registers follow stage for stage.
    always_ff @(posedge clk)
    begin
        if (r1_take)
        begin
            yaw_s1_reg   <= in_data.yaw_angle;
            pitch_s1_reg <= in_data.pitch_angle;
        end
    end

    // About Y by camera tilt: pair (z, x), y passes
    ptcb_rot #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rot_tilt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_take   (r1_take),
        .angle     (tilt_reg),
        .a         (sw_z),
        .b         (sw_x),
        .t         (sw_y),
        .off_a     (cam_oz),
        .off_b     (cam_ox),
        .off_t     (cam_oy),
        .out_valid (r1_valid),
        .out_take  (r2_take),
        .out_a     (r1_z),
        .out_b     (r1_x),
        .out_t     (r1_y)
    );

    // Angle delay matched to the three stages of the first rotation
    logic s2_take_t, s3_take_t;
    logic [2:0] d1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d1_valid_reg <= '0;
        else
        begin
            if (r1_take)
                d1_valid_reg[0] <= in_valid;
            if (s2_take_t)
                d1_valid_reg[1] <= d1_valid_reg[0];
            if (s3_take_t)
                d1_valid_reg[2] <= d1_valid_reg[1];
        end
    end

    assign s3_take_t = !d1_valid_reg[2] || r2_take;
    assign s2_take_t = !d1_valid_reg[1] || s3_take_t;

    always_ff @(posedge clk)
    begin
        if (s2_take_t)
        begin
            yaw_s2_reg   <= yaw_s1_reg;
            pitch_s2_reg <= pitch_s1_reg;
        end
        if (s3_take_t)
        begin
            yaw_s3_reg   <= yaw_s2_reg;
            pitch_s3_reg <= pitch_s2_reg;
        end
    end

    // About Y by pitch
    ptcb_rot #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rot_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r1_valid),
        .in_take   (r2_take),
        .angle     (pitch_s3_reg),
        .a         (r1_z),
        .b         (r1_x),
        .t         (r1_y),
        .off_a     (pit_oz),
        .off_b     (pit_ox),
        .off_t     (pit_oy),
        .out_valid (r2_valid),
        .out_take  (r3_take),
        .out_a     (r2_z),
        .out_b     (r2_x),
        .out_t     (r2_y)
    );

    logic s5_take_t, s6_take_t;
    logic [2:0] d2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d2_valid_reg <= '0;
        else
        begin
            if (r2_take)
                d2_valid_reg[0] <= r1_valid;
            if (s5_take_t)
                d2_valid_reg[1] <= d2_valid_reg[0];
            if (s6_take_t)
                d2_valid_reg[2] <= d2_valid_reg[1];
        end
    end

    assign s6_take_t = !d2_valid_reg[2] || r3_take;
    assign s5_take_t = !d2_valid_reg[1] || s6_take_t;

    always_ff @(posedge clk)
    begin
        if (r2_take)
            yaw_s4_reg <= yaw_s3_reg;
        if (s5_take_t)
            yaw_s5_reg <= yaw_s4_reg;
        if (s6_take_t)
            yaw_s6_reg <= yaw_s5_reg;
    end

    // About Z by yaw: pair (x, y), z passes; last stage is the output register
    ptcb_rot #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rot_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r2_valid),
        .in_take   (r3_take),
        .angle     (yaw_s6_reg),
        .a         (r2_x),
        .b         (r2_y),
        .t         (r2_z),
        .off_a     (yaw_ox),
        .off_b     (yaw_oy),
        .off_t     (yaw_oz),
        .out_valid (r3_valid),
        .out_take  (!out_stall),
        .out_a     (r3_x),
        .out_b     (r3_y),
        .out_t     (r3_z)
    );

    assign out_valid       = r3_valid;
    assign out_data.base_x = r3_x[31:0];
    assign out_data.base_y = r3_y[31:0];
    assign out_data.base_z = r3_z[31:0];

endmodule

// ===== src/ptcb_checker.sv =====
`timescale 1ns / 1ps

module ptcb_checker
    import ptcb_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input ptcb_out_t              out_data
);

    logic in_xfer;

    assign in_xfer = in_valid && !in_stall;

    // A held result stays put until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed before transfer");

    // Input backpressure only comes from a full pipe behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

    // With no output stall in between, every input transfer comes out as out_valid
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_xfer, 9) && $past(rst_n, 9) && $past(rst_n, 8) && $past(rst_n, 7)
        && $past(rst_n, 6) && $past(rst_n, 5) && $past(rst_n, 4) && $past(rst_n, 3)
        && $past(rst_n, 2) && $past(rst_n, 1)
        && !$past(out_stall, 1) && !$past(out_stall, 2) && !$past(out_stall, 3)
        && !$past(out_stall, 4) && !$past(out_stall, 5) && !$past(out_stall, 6)
        && !$past(out_stall, 7) && !$past(out_stall, 8)
        |-> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind pan_tilt_camera_point_to_base_top ptcb_checker u_ptcb_checker (.*);
